// File: src/lmma_pkg.sv
// Shared types, constants and tables for the LED matrix mood animator.
// Used by every module of the block; depends on nothing.
package lmma_pkg;

	// Number of fluid particles and the width of a particle index.
	localparam int NUM_PARTICLES = 5;
	localparam int PART_W = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

	// Configuration register indexes.
	localparam logic REG_MODE = 1'b0;
	localparam logic REG_MUTE = 1'b1;

	// Display mode codes.
	localparam logic [3:0] MODE_DISCONNECTED = 4'd0;
	localparam logic [3:0] MODE_CONNECTING   = 4'd1;
	localparam logic [3:0] MODE_IDLE         = 4'd2;
	localparam logic [3:0] MODE_LISTENING    = 4'd3;
	localparam logic [3:0] MODE_UPLOADING    = 4'd4;
	localparam logic [3:0] MODE_TRANSCRIBING = 4'd5;
	localparam logic [3:0] MODE_THINKING     = 4'd6;
	localparam logic [3:0] MODE_SPEAKING     = 4'd7;
	localparam logic [3:0] MODE_ERROR        = 4'd8;
	localparam logic [3:0] MODE_MUTED        = 4'd9;

	// Fluid arithmetic constants.
	localparam logic [14:0] DIV52_MUL = 15'd20165;
	localparam logic [9:0]  POS_LO    = 10'd40;
	localparam logic [9:0]  POS_HI    = 10'd984;
	localparam logic [7:0]  GLOW_NONE = 8'd255;

	// Last pixel index of a frame.
	localparam logic [4:0] LAST_PIX = 5'd24;
	// Last put step of a non-fluid frame.
	localparam logic [3:0] LAST_SHAPE_STEP = 4'd12;
	// Last put step of one particle.
	localparam logic [3:0] LAST_PART_STEP = 4'd4;

	// One input beat.
	typedef struct packed {
		logic signed [11:0] accel_x;
		logic signed [11:0] accel_y;
		logic [7:0]         mic_level;
		logic [7:0]         speaker_level;
	} in_beat_t;

	// One output beat.
	typedef struct packed {
		logic [4:0] pixel_index;
		logic [7:0] pixel_value;
		logic       final_pixel;
		logic       glow_write;
		logic [6:0] glow_level;
	} out_beat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              start;
		logic              setup;
		logic              vel;
		logic              pos;
		logic              put;
		logic              emit;
		logic [PART_W-1:0] part;
		logic [3:0]        sub;
		logic [4:0]        pix;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fluid;
		logic out_free;
	} dp_status_t;

	// Start positions of the particles.
	function automatic logic [9:0] start_x(input logic [2:0] i);
		logic [9:0] r;
		case (i)
			3'd0: r = 10'd256;
			3'd1: r = 10'd768;
			3'd2: r = 10'd512;
			3'd3: r = 10'd128;
			3'd4: r = 10'd896;
			3'd5: r = 10'd512;
			3'd6: r = 10'd128;
			default: r = 10'd896;
		endcase
		return r;
	endfunction

	function automatic logic [9:0] start_y(input logic [2:0] i);
		logic [9:0] r;
		case (i)
			3'd0: r = 10'd256;
			3'd1: r = 10'd256;
			3'd2: r = 10'd512;
			3'd3: r = 10'd832;
			3'd4: r = 10'd832;
			3'd5: r = 10'd128;
			3'd6: r = 10'd512;
			default: r = 10'd512;
		endcase
		return r;
	endfunction

	// Border ring walked by the comet, as {x, y}.
	function automatic logic [5:0] ring_xy(input logic [3:0] k);
		logic [5:0] r;
		case (k)
			4'd0:  r = {3'd2, 3'd0};
			4'd1:  r = {3'd3, 3'd0};
			4'd2:  r = {3'd4, 3'd1};
			4'd3:  r = {3'd4, 3'd2};
			4'd4:  r = {3'd4, 3'd3};
			4'd5:  r = {3'd3, 3'd4};
			4'd6:  r = {3'd2, 3'd4};
			4'd7:  r = {3'd1, 3'd4};
			4'd8:  r = {3'd0, 3'd3};
			4'd9:  r = {3'd0, 3'd2};
			4'd10: r = {3'd0, 3'd1};
			default: r = {3'd1, 3'd0};
		endcase
		return r;
	endfunction

endpackage

// File: src/lmma_ctrl.sv
// Controller state machine of the mood animator: sequences setup, particle
// updates, pixel plotting and the 25 output beats. Depends on lmma_pkg.
module lmma_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output lmma_pkg::dp_cmd_t    cmd,
	input  lmma_pkg::dp_status_t status
);
	import lmma_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SETUP = 6'b000010,
		S_VEL   = 6'b000100,
		S_POS   = 6'b001000,
		S_PUT   = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [PART_W-1:0] part_q;
	logic [3:0]        sub_q;
	logic [4:0]        pix_q;
	logic              last_part;

	assign in_ready  = (state_q == S_IDLE);
	assign last_part = (part_q == PART_W'(NUM_PARTICLES - 1));

	// Command decode.
	always_comb begin
		cmd       = '0;
		cmd.start = in_valid && in_ready;
		cmd.setup = (state_q == S_SETUP);
		cmd.vel   = (state_q == S_VEL);
		cmd.pos   = (state_q == S_POS);
		cmd.put   = (state_q == S_PUT);
		cmd.emit  = (state_q == S_EMIT) && status.out_free;
		cmd.part  = part_q;
		cmd.sub   = sub_q;
		cmd.pix   = pix_q;
	end

	// Sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			part_q  <= '0;
			sub_q   <= '0;
			pix_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					part_q  <= '0;
					sub_q   <= '0;
					pix_q   <= '0;
					state_q <= status.fluid ? S_VEL : S_PUT;
				end
				S_VEL: begin
					state_q <= S_POS;
				end
				S_POS: begin
					sub_q   <= '0;
					state_q <= S_PUT;
				end
				S_PUT: begin
					sub_q <= sub_q + 4'd1;
					if (status.fluid) begin
						if (sub_q == LAST_PART_STEP) begin
							if (last_part) begin
								state_q <= S_EMIT;
							end else begin
								part_q  <= part_q + PART_W'(1);
								state_q <= S_VEL;
							end
						end
					end else if (sub_q == LAST_SHAPE_STEP) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (status.out_free) begin
						pix_q <= pix_q + 5'd1;
						if (pix_q == LAST_PIX) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The frame ends right after its last beat is loaded.
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && pix_q == LAST_PIX && status.out_free) |=> (state_q == S_IDLE))
		else $error("frame did not end after last beat");

	// A new tick is never taken while plotting or emitting.
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> (!cmd.put && !cmd.emit && !cmd.vel && !cmd.pos))
		else $error("tick accepted while busy");

	// Pixel counter never passes the last pixel.
	a_pix_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (pix_q <= LAST_PIX))
		else $error("pixel counter out of range");

endmodule

// File: src/lmma_datapath.sv
// Datapath of the mood animator: tick state, particles, frame buffer,
// glow logic, configuration registers and the output register. Uses lmma_pkg.
module lmma_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lmma_pkg::dp_cmd_t    cmd,
	output lmma_pkg::dp_status_t status,
	input  lmma_pkg::in_beat_t   in_data,
	input  logic                 write_enable,
	input  logic                 reg_index,
	input  logic [3:0]           write_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lmma_pkg::out_beat_t  out_data
);
	import lmma_pkg::*;

	typedef enum logic [2:0] {
		K_FLUID_DIM, K_FLUID_BRIGHT, K_COMET_CONN, K_COMET_THINK,
		K_LISTEN, K_SPEAK, K_PULSE, K_ERROR
	} kind_t;

	// Configuration and tick state.
	logic [3:0]  mode_q;
	logic        mute_q;
	logic [31:0] frame_q;
	logic [3:0]  r11_q, r9_q, r10_q;
	logic [4:0]  r24_q;
	in_beat_t    in_q;
	logic signed [5:0] gx_q, gy_q;
	logic [3:0]  jr11_q, jr9_q;
	logic [1:0]  glow_div_q;
	logic [7:0]  last_glow_q;
	logic        gw_q;
	logic [6:0]  gl_q;

	// Particle state.
	logic [9:0]        pos_x_q [NUM_PARTICLES];
	logic [9:0]        pos_y_q [NUM_PARTICLES];
	logic signed [15:0] vel_x_q [NUM_PARTICLES];
	logic signed [15:0] vel_y_q [NUM_PARTICLES];
	logic signed [15:0] vdx_s1, vdy_s1;
	logic [2:0]  cx_q, cy_q;

	// Frame buffer and output register.
	logic [7:0]  buf_q [25];
	logic        out_valid_q;
	out_beat_t   out_q;

	kind_t kind;
	logic  mute_path;

	// Render kind follows the mode and mute registers.
	always_comb begin
		mute_path = mute_q && (mode_q != MODE_LISTENING) && (mode_q != MODE_UPLOADING);
		if (mode_q == MODE_CONNECTING) begin
			kind = K_COMET_CONN;
		end else if (mute_path) begin
			kind = K_PULSE;
		end else begin
			case (mode_q)
				MODE_DISCONNECTED: kind = K_FLUID_DIM;
				MODE_IDLE:         kind = K_FLUID_BRIGHT;
				MODE_LISTENING:    kind = K_LISTEN;
				MODE_THINKING:     kind = K_COMET_THINK;
				MODE_SPEAKING:     kind = K_SPEAK;
				MODE_ERROR:        kind = K_ERROR;
				default:           kind = K_PULSE;
			endcase
		end
	end

	assign status.fluid    = (kind == K_FLUID_DIM) || (kind == K_FLUID_BRIGHT);
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

	// Gravity term: a / 52 toward zero by reciprocal, clamped to +-20.
	function automatic logic signed [5:0] grav(input logic signed [11:0] a);
		logic [11:0] mag;
		logic [26:0] prod;
		logic [6:0]  q;
		mag  = a[11] ? 12'(-a) : 12'(a);
		prod = 27'(mag) * 27'(DIV52_MUL);
		q    = prod[26:20];
		if (q > 7'd20) begin
			q = 7'd20;
		end
		return a[11] ? -$signed({1'b0, q[4:0]}) : $signed({1'b0, q[4:0]});
	endfunction

	// Glow target.
	logic [4:0] f5, wave;
	logic [7:0] glvl;
	logic [6:0] target;
	logic [8:0] gdiff;
	logic [2:0] div_inc;
	logic       glow_on;

	always_comb begin
		f5      = frame_q[4:0];
		wave    = (f5 > 5'd16) ? 5'(6'd32 - {1'b0, f5}) : f5;
		glvl    = mute_path ? 8'd0 :
			((mode_q == MODE_LISTENING) ? in_q.mic_level : in_q.speaker_level);
		glow_on = (mode_q != MODE_DISCONNECTED) && (mode_q != MODE_CONNECTING);
		div_inc = {1'b0, glow_div_q} + 3'd1;
		case (mode_q)
			MODE_IDLE:         target = 7'd18 + 7'(wave);
			MODE_LISTENING:    target = 7'd24 + 7'(glvl[7:2]);
			MODE_UPLOADING:    target = 7'd35 + 7'({wave, 1'b0});
			MODE_TRANSCRIBING: target = 7'd40 + 7'(wave);
			MODE_THINKING:     target = 7'd42 + 7'({wave, 1'b0});
			MODE_SPEAKING:     target = 7'd28 + 7'(glvl[7:2]);
			MODE_ERROR:        target = 7'd90;
			MODE_MUTED:        target = 7'd10 + 7'(wave[4:1]);
			default:           target = 7'd16;
		endcase
		gdiff = ({2'b0, target} >= {1'b0, last_glow_q}) ?
			({2'b0, target} - {1'b0, last_glow_q}) : ({1'b0, last_glow_q} - {2'b0, target});
	end

	// Particle velocity step.
	logic signed [4:0]  jx, jy, jxh, jyh;
	logic signed [15:0] v1x, v1y, v2x, v2y;
	logic signed [20:0] mx, my, dx, dy;

	always_comb begin
		jx  = $signed({1'b0, jr11_q}) - 5'sd5;
		jy  = $signed({1'b0, jr9_q}) - 5'sd4;
		jxh = (jx + $signed({4'b0, jx[4]})) >>> 1;
		jyh = (jy + $signed({4'b0, jy[4]})) >>> 1;
		v1x = vel_x_q[cmd.part] + 16'(gx_q);
		v1y = vel_y_q[cmd.part] + 16'(gy_q);
		v2x = v1x + 16'(jxh);
		v2y = v1y + 16'(jyh);
		mx  = 21'(v2x) * 21'sd29;
		my  = 21'(v2y) * 21'sd29;
		dx  = (mx + (mx[20] ? 21'sd31 : 21'sd0)) >>> 5;
		dy  = (my + (my[20] ? 21'sd31 : 21'sd0)) >>> 5;
	end

	// Particle position step with wall bounce.
	logic signed [17:0] psx, psy;
	logic signed [15:0] hx, hy, nvx, nvy;
	logic [9:0]  npx, npy;
	logic [10:0] rx, ry;

	always_comb begin
		psx = $signed({8'b0, pos_x_q[cmd.part]}) + 18'(vdx_s1);
		psy = $signed({8'b0, pos_y_q[cmd.part]}) + 18'(vdy_s1);
		hx  = (vdx_s1 + $signed({15'b0, vdx_s1[15]})) >>> 1;
		hy  = (vdy_s1 + $signed({15'b0, vdy_s1[15]})) >>> 1;
		npx = psx[9:0];
		nvx = vdx_s1;
		if (psx < $signed({8'b0, POS_LO})) begin
			npx = POS_LO;
			nvx = -hx;
		end else if (psx > $signed({8'b0, POS_HI})) begin
			npx = POS_HI;
			nvx = -hx;
		end
		npy = psy[9:0];
		nvy = vdy_s1;
		if (psy < $signed({8'b0, POS_LO})) begin
			npy = POS_LO;
			nvy = -hy;
		end else if (psy > $signed({8'b0, POS_HI})) begin
			npy = POS_HI;
			nvy = -hy;
		end
		rx = {1'b0, npx} + 11'd128;
		ry = {1'b0, npy} + 11'd128;
	end

	// Plot source for the current put step.
	logic signed [3:0] put_x, put_y, fcx, fcy;
	logic [8:0] put_v, core, halo, pb, p3v, p2v, p4v;
	logic [7:0] lvl;
	logic [15:0] lprod;
	logic [4:0]  d24, hk;
	logic [3:0]  head, kk;
	logic [2:0]  tail, ei;
	logic [8:0]  ctop, cfall, ccen;
	logic [5:0]  rxy;
	logic        w;

	always_comb begin
		lvl   = (kind == K_LISTEN) ? in_q.mic_level : in_q.speaker_level;
		lprod = 16'(lvl) * 16'd171;
		p3v   = 9'(lprod[15:9]);
		p2v   = 9'(lvl[7:1]);
		p4v   = 9'(lvl[7:2]);
		core  = (kind == K_FLUID_DIM) ? 9'd105 : 9'd170;
		halo  = (kind == K_FLUID_DIM) ? 9'd24 : 9'd40;
		fcx   = $signed({1'b0, cx_q});
		fcy   = $signed({1'b0, cy_q});
		d24   = (r24_q < 5'd12) ? r24_q : 5'(5'd24 - r24_q);
		pb    = 9'd55 + 9'(d24) * 9'd12;
		w     = frame_q[1];
		head  = r24_q[4:1];
		hk    = {1'b0, head} - {1'b0, cmd.sub};
		kk    = hk[4] ? 4'(hk + 5'd12) : hk[3:0];
		rxy   = ring_xy(kk);
		ei    = cmd.sub[3:1];
		if (kind == K_COMET_CONN) begin
			tail  = 3'd4;
			ctop  = 9'd235;
			cfall = 9'd55;
			ccen  = frame_q[2] ? 9'd110 : 9'd35;
		end else begin
			tail  = 3'd5;
			ctop  = 9'd220;
			cfall = 9'd42;
			ccen  = 9'd22;
		end
		put_x = 4'sd0;
		put_y = 4'sd0;
		put_v = 9'd0;
		case (kind)
			K_FLUID_DIM, K_FLUID_BRIGHT: begin
				put_x = fcx;
				put_y = fcy;
				put_v = halo;
				case (cmd.sub)
					4'd0: put_v = core;
					4'd1: put_x = fcx - 4'sd1;
					4'd2: put_x = fcx + 4'sd1;
					4'd3: put_y = fcy - 4'sd1;
					4'd4: put_y = fcy + 4'sd1;
					default: put_v = 9'd0;
				endcase
			end
			K_COMET_CONN, K_COMET_THINK: begin
				if (cmd.sub < {1'b0, tail}) begin
					put_x = $signed({1'b0, rxy[5:3]});
					put_y = $signed({1'b0, rxy[2:0]});
					put_v = ctop - 9'(cmd.sub[2:0]) * cfall;
				end else if (cmd.sub == {1'b0, tail}) begin
					put_x = 4'sd2;
					put_y = 4'sd2;
					put_v = ccen;
				end
			end
			K_LISTEN: begin
				case (cmd.sub)
					4'd0: begin put_x = 4'sd2; put_y = 4'sd2; put_v = 9'd150 + p3v; end
					4'd1: begin put_x = 4'sd2; put_y = 4'sd1; put_v = 9'd95 + p3v; end
					4'd2: begin put_x = 4'sd2; put_y = 4'sd3; put_v = 9'd95 + p3v; end
					4'd3: begin put_x = 4'sd1; put_y = 4'sd2; put_v = 9'd95 + p3v; end
					4'd4: begin put_x = 4'sd3; put_y = 4'sd2; put_v = 9'd95 + p3v; end
					4'd5: begin put_x = 4'sd1; put_y = 4'sd1; end
					4'd6: begin put_x = 4'sd3; put_y = 4'sd1; end
					4'd7: begin put_x = 4'sd1; put_y = 4'sd3; end
					4'd8: begin put_x = 4'sd3; put_y = 4'sd3; end
					4'd9: begin put_x = 4'sd2; put_y = 4'sd0; end
					4'd10: begin put_x = 4'sd4; put_y = 4'sd2; end
					4'd11: begin put_x = 4'sd2; put_y = 4'sd4; end
					4'd12: begin put_x = 4'sd0; put_y = 4'sd2; end
					default: put_v = 9'd0;
				endcase
				// Outer rings appear only for louder input.
				if (cmd.sub >= 4'd5 && cmd.sub <= 4'd8 && lvl > 8'd45) begin
					put_v = 9'd28 + p2v;
				end
				if (cmd.sub >= 4'd9 && cmd.sub <= 4'd12 && lvl > 8'd120) begin
					put_v = 9'd28 + p2v;
				end
			end
			K_SPEAK: begin
				case (cmd.sub)
					4'd0: begin put_x = 4'sd1; put_y = 4'sd2; put_v = 9'd120 + p3v; end
					4'd1: begin put_x = 4'sd3; put_y = 4'sd2; put_v = 9'd120 + p3v; end
					4'd2: begin put_x = 4'sd2; put_y = 4'sd2; put_v = 9'd65 + p4v; end
					4'd3: begin
						put_x = 4'sd1;
						put_y = w ? 4'sd2 : 4'sd1;
						put_v = 9'd50 + p3v;
					end
					4'd4: begin
						put_x = 4'sd3;
						put_y = w ? 4'sd1 : 4'sd2;
						put_v = 9'd50 + p3v;
					end
					4'd5: begin
						put_x = 4'sd0;
						put_y = 4'sd2;
						put_v = (lvl > 8'd55) ? 9'd30 + p2v : 9'd0;
					end
					4'd6: begin
						put_x = 4'sd4;
						put_y = 4'sd2;
						put_v = (lvl > 8'd55) ? 9'd30 + p2v : 9'd0;
					end
					4'd7: begin
						put_x = 4'sd1;
						put_y = 4'sd0;
						put_v = (lvl > 8'd135) ? 9'd36 + p3v : 9'd0;
					end
					4'd8: begin
						put_x = 4'sd3;
						put_y = 4'sd4;
						put_v = (lvl > 8'd135) ? 9'd36 + p3v : 9'd0;
					end
					default: put_v = 9'd0;
				endcase
			end
			K_ERROR: begin
				if (cmd.sub < 4'd10) begin
					put_y = $signed({1'b0, ei});
					put_x = cmd.sub[0] ? $signed({1'b0, 3'(3'd4 - ei)}) : $signed({1'b0, ei});
					put_v = (r10_q >= 4'd5) ? 9'd240 : 9'd80;
				end
			end
			K_PULSE: begin
				put_x = 4'sd2;
				put_y = 4'sd2;
				put_v = pb >> 1;
				case (cmd.sub)
					4'd0: put_v = pb;
					4'd1: put_x = 4'sd1;
					4'd2: put_x = 4'sd3;
					4'd3: put_y = 4'sd1;
					4'd4: put_y = 4'sd3;
					default: put_v = 9'd0;
				endcase
			end
			default: put_v = 9'd0;
		endcase
	end

	// Saturating read-modify-write into the frame buffer.
	logic       put_en;
	logic [4:0] put_idx, rd_addr;
	logic [7:0] rd_val;
	logic [9:0] sum;

	always_comb begin
		put_en  = cmd.put && !put_x[3] && (put_x <= 4'sd4) && !put_y[3] &&
			(put_y <= 4'sd4) && (put_v != 9'd0);
		put_idx = 5'(put_y[2:0]) * 5'd5 + 5'(put_x[2:0]);
		rd_addr = cmd.emit ? cmd.pix : put_idx;
		rd_val  = (rd_addr <= LAST_PIX) ? buf_q[rd_addr] : 8'd0;
		sum     = {2'b0, rd_val} + {1'b0, put_v};
	end

	// Tick, particle, glow and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_DISCONNECTED;
			mute_q      <= 1'b0;
			frame_q     <= '0;
			r11_q       <= '0;
			r9_q        <= '0;
			r10_q       <= '0;
			r24_q       <= '0;
			glow_div_q  <= '0;
			last_glow_q <= GLOW_NONE;
			gw_q        <= 1'b0;
			for (int i = 0; i < NUM_PARTICLES; i++) begin
				pos_x_q[i] <= start_x(3'(i));
				pos_y_q[i] <= start_y(3'(i));
				vel_x_q[i] <= '0;
				vel_y_q[i] <= '0;
			end
		end else begin
			// Configuration writes.
			if (write_enable) begin
				if (reg_index == REG_MODE) begin
					if (write_data != mode_q) begin
						mode_q      <= write_data;
						glow_div_q  <= '0;
						last_glow_q <= GLOW_NONE;
					end
				end else begin
					mute_q <= write_data[0];
				end
			end
			// New tick: advance the frame counter and its residues.
			if (cmd.start) begin
				frame_q <= frame_q + 32'd1;
				if (frame_q == 32'hFFFF_FFFF) begin
					r11_q <= '0;
					r9_q  <= '0;
					r10_q <= '0;
					r24_q <= '0;
				end else begin
					r11_q <= (r11_q == 4'd10) ? 4'd0 : r11_q + 4'd1;
					r9_q  <= (r9_q >= 4'd6) ? 4'(r9_q - 4'd6) : r9_q + 4'd3;
					r10_q <= (r10_q == 4'd9) ? 4'd0 : r10_q + 4'd1;
					r24_q <= (r24_q == 5'd23) ? 5'd0 : r24_q + 5'd1;
				end
			end
			// Glow check once per tick while glow is on; the level may change only on every fourth tick.
			if (cmd.setup) begin
				gw_q <= 1'b0;
				if (glow_on) begin
					if (div_inc[2]) begin
						glow_div_q <= '0;
						if (last_glow_q == GLOW_NONE || gdiff >= 9'd2) begin
							last_glow_q <= {1'b0, target};
							gw_q        <= 1'b1;
						end
					end else begin
						glow_div_q <= div_inc[1:0];
					end
				end
			end
			// Particle writeback.
			if (cmd.pos) begin
				pos_x_q[cmd.part] <= npx;
				pos_y_q[cmd.part] <= npy;
				vel_x_q[cmd.part] <= nvx;
				vel_y_q[cmd.part] <= nvy;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			in_q <= in_data;
			for (int i = 0; i < 25; i++) begin
				buf_q[i] <= 8'd0;
			end
		end
		if (cmd.setup) begin
			gx_q   <= grav(in_q.accel_x);
			gy_q   <= grav(in_q.accel_y);
			jr11_q <= r11_q;
			jr9_q  <= r9_q;
			gl_q   <= target;
		end
		if (cmd.vel) begin
			vdx_s1 <= dx[15:0];
			vdy_s1 <= dy[15:0];
		end
		if (cmd.pos) begin
			cx_q   <= rx[10:8];
			cy_q   <= ry[10:8];
			jr11_q <= (jr11_q >= 4'd4) ? 4'(jr11_q - 4'd4) : jr11_q + 4'd7;
			jr9_q  <= (jr9_q >= 4'd4) ? 4'(jr9_q - 4'd4) : jr9_q + 4'd5;
		end
		if (put_en) begin
			buf_q[put_idx] <= (sum > 10'd255) ? 8'd255 : sum[7:0];
		end
		if (cmd.emit) begin
			out_q.pixel_index <= cmd.pix;
			out_q.pixel_value <= rd_val;
			out_q.final_pixel <= (cmd.pix == LAST_PIX);
			out_q.glow_write  <= (cmd.pix == LAST_PIX) && gw_q;
			out_q.glow_level  <= ((cmd.pix == LAST_PIX) && gw_q) ? gl_q : 7'd0;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: src/led_matrix_mood_animator.sv
// Top level of the LED matrix mood animator: controller plus datapath.
// Depends on lmma_pkg, lmma_ctrl and lmma_datapath.
// Each accepted tick runs a setup step, then in fluid modes a velocity step,
// a position step and the put steps for each of the five particles, or else
// the shape's put steps, then the output beats, one per cycle unless the sink
// stalls. No new tick is taken until the frame's last beat is loaded.
// Reset clears the frame counter, glow state and configuration registers and
// restores the particle start positions at once; there is no clearing pass.
module led_matrix_mood_animator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lmma_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lmma_pkg::out_beat_t out_data,
	input  logic                write_enable,
	input  logic                reg_index,
	input  logic [3:0]          write_data
);
	import lmma_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	lmma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	lmma_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.in_data      (in_data),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data)
	);

	// The final flag marks exactly the last pixel of a frame.
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.final_pixel == (out_data.pixel_index == LAST_PIX)))
		else $error("final flag on wrong pixel");

	// A glow write only rides on the final pixel.
	a_glow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.glow_write) |-> out_data.final_pixel)
		else $error("glow write off the final pixel");

endmodule
